// ===== rtl/core/assert_macros.svh =====
// Assertion helpers. Clock and reset names are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/dbcs_pkg.sv =====
`default_nettype none
package dbcs_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam int DEBOUNCE_W = 10;
  localparam int LIMIT_W    = 16;
  localparam int POT_W      = 10;
  localparam int HOUR_W     = 5;
  localparam int MINUTE_W   = 6;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERY_LONG_PRESS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TO_SELECT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_GUARD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POT_THRESHOLD   = 3'd5;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MS_RST     = 10'd50;
  localparam logic [LIMIT_W-1:0]    SHORT_PRESS_RST     = 16'd3000;
  localparam logic [LIMIT_W-1:0]    VERY_LONG_PRESS_RST = 16'd10000;
  localparam logic [LIMIT_W-1:0]    HOLD_TO_SELECT_RST  = 16'd1000;
  localparam logic [LIMIT_W-1:0]    SELECT_GUARD_RST    = 16'd1000;
  localparam logic [POT_W-1:0]      POT_THRESHOLD_RST   = 10'd512;

  localparam logic [MODE_W-1:0] MODE_CLOCK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SET   = 2'd2;

  localparam logic [MINUTE_W:0] MINUTES_PER_HOUR = 7'd60;
  localparam logic [HOUR_W:0]   HOURS_PER_DAY    = 6'd24;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ms;
    logic [LIMIT_W-1:0]    short_press_limit;
    logic [LIMIT_W-1:0]    very_long_press;
    logic [LIMIT_W-1:0]    hold_to_select;
    logic [LIMIT_W-1:0]    select_guard;
    logic [POT_W-1:0]      pot_threshold;
  } cfg_t;

  typedef struct packed {
    logic              raw_button;
    logic [POT_W-1:0]  pot_value;
    logic [HOUR_W-1:0] current_hour;
    logic [MINUTE_W-1:0] current_minute;
  } in_item_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic                set_valid;
    logic [HOUR_W-1:0]   set_hour;
    logic [MINUTE_W-1:0] set_minute;
    logic                selection_is_set;
  } res_t;

  // button flags and mode state carried between the state regs and the step logic
  typedef struct packed {
    logic              last_raw;
    logic              stable_level;
    logic              press_active;
    logic [MODE_W-1:0] mode;
  } flags_t;

endpackage
`default_nettype wire

// ===== rtl/core/dbcs_in_if.sv =====
`default_nettype none
interface dbcs_in_if;
  import dbcs_pkg::*;

  logic                valid;
  logic                ready;
  logic                raw_button;
  logic [POT_W-1:0]    pot_value;
  logic [HOUR_W-1:0]   current_hour;
  logic [MINUTE_W-1:0] current_minute;

  modport source (output valid, output raw_button, output pot_value,
                  output current_hour, output current_minute, input ready);
  modport sink   (input valid, input raw_button, input pot_value,
                  input current_hour, input current_minute, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dbcs_out_if.sv =====
`default_nettype none
interface dbcs_out_if;
  import dbcs_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic                set_valid;
  logic [HOUR_W-1:0]   set_hour;
  logic [MINUTE_W-1:0] set_minute;
  logic                selection_is_set;

  modport source (output valid, output mode, output set_valid, output set_hour,
                  output set_minute, output selection_is_set, input ready);
  modport sink   (input valid, input mode, input set_valid, input set_hour,
                  input set_minute, input selection_is_set, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dbcs_cfg_regs.sv =====
`default_nettype none
module dbcs_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [dbcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dbcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output dbcs_pkg::cfg_t                       cfg
);
  import dbcs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_MS:     cfg_nxt.debounce_ms       = cfg_wdata[DEBOUNCE_W-1:0];
        CFG_SHORT_PRESS:     cfg_nxt.short_press_limit = cfg_wdata[LIMIT_W-1:0];
        CFG_VERY_LONG_PRESS: cfg_nxt.very_long_press   = cfg_wdata[LIMIT_W-1:0];
        CFG_HOLD_TO_SELECT:  cfg_nxt.hold_to_select    = cfg_wdata[LIMIT_W-1:0];
        CFG_SELECT_GUARD:    cfg_nxt.select_guard      = cfg_wdata[LIMIT_W-1:0];
        CFG_POT_THRESHOLD:   cfg_nxt.pot_threshold     = cfg_wdata[POT_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms       <= DEBOUNCE_MS_RST;
      cfg_r.short_press_limit <= SHORT_PRESS_RST;
      cfg_r.very_long_press   <= VERY_LONG_PRESS_RST;
      cfg_r.hold_to_select    <= HOLD_TO_SELECT_RST;
      cfg_r.select_guard      <= SELECT_GUARD_RST;
      cfg_r.pot_threshold     <= POT_THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule
`default_nettype wire

// ===== rtl/core/dbcs_step.sv =====
`default_nettype none
module dbcs_step #(
  parameter int COUNT_BITS = dbcs_pkg::COUNT_BITS_DEF
) (
  input  wire dbcs_pkg::cfg_t         cfg,
  input  wire dbcs_pkg::in_item_t     item,
  input  wire dbcs_pkg::flags_t       flags,
  input  wire logic [COUNT_BITS-1:0]  stable_ticks,
  input  wire logic [COUNT_BITS-1:0]  press_ticks,
  input  wire logic [COUNT_BITS-1:0]  select_ticks,
  output dbcs_pkg::flags_t            flags_nxt,
  output logic [COUNT_BITS-1:0]       stable_ticks_nxt,
  output logic [COUNT_BITS-1:0]       press_ticks_nxt,
  output logic [COUNT_BITS-1:0]       select_ticks_nxt,
  output dbcs_pkg::res_t              res
);
  import dbcs_pkg::*;

  // common width for counter vs. limit compares
  localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  logic [COUNT_BITS-1:0] dur;
  logic [MINUTE_W:0]     min_inc;
  logic [HOUR_W:0]       hour_inc;
  logic [MINUTE_W-1:0]   min_wrap;
  logic [HOUR_W-1:0]     hour_wrap;
  logic                  pot_set;
  logic                  level_change;

  assign min_inc   = {1'b0, item.current_minute} + 7'd1;
  assign hour_inc  = {1'b0, item.current_hour} + 6'd1;
  assign min_wrap  = (min_inc >= MINUTES_PER_HOUR) ? 
                     MINUTE_W'(min_inc - MINUTES_PER_HOUR) : min_inc[MINUTE_W-1:0];
  assign hour_wrap = (hour_inc >= HOURS_PER_DAY) ?
                     HOUR_W'(hour_inc - HOURS_PER_DAY) : hour_inc[HOUR_W-1:0];
  assign pot_set   = item.pot_value >= cfg.pot_threshold;

  always_comb begin
    dur              = flags.press_active ? sat_inc(press_ticks) : press_ticks;
    press_ticks_nxt  = dur;
    select_ticks_nxt = sat_inc(select_ticks);
    stable_ticks_nxt = (item.raw_button != flags.last_raw) ? '0 : sat_inc(stable_ticks);
    flags_nxt          = flags;
    flags_nxt.last_raw = item.raw_button;
    res                = '0;
    level_change = (CMP_W'(stable_ticks_nxt) > CMP_W'(cfg.debounce_ms)) &&
                   (item.raw_button != flags.stable_level);

    if (level_change) begin
      flags_nxt.stable_level = item.raw_button;
      if (!item.raw_button) begin
        if (!flags.press_active) begin
          flags_nxt.press_active = 1'b1;
          press_ticks_nxt        = '0;
        end
      end else begin
        flags_nxt.press_active = 1'b0;
        press_ticks_nxt        = '0;
        if (flags.mode == MODE_SET) begin
          // release with no timed press is dropped
          if (flags.press_active) begin
            if (CMP_W'(dur) < CMP_W'(cfg.short_press_limit)) begin
              res.set_valid  = 1'b1;
              res.set_hour   = item.current_hour;
              res.set_minute = min_wrap;
            end else if (CMP_W'(dur) < CMP_W'(cfg.very_long_press)) begin
              res.set_valid  = 1'b1;
              res.set_hour   = hour_wrap;
              res.set_minute = item.current_minute;
            end else begin
              flags_nxt.mode = MODE_CLOCK;
            end
          end
        end else if (flags.mode == MODE_PICK) begin
          if (CMP_W'(select_ticks_nxt) > CMP_W'(cfg.select_guard)) begin
            flags_nxt.mode = pot_set ? MODE_SET : MODE_CLOCK;
          end
        end
      end
    end

    // long hold in clock mode; ends the press timing
    if (flags_nxt.mode != MODE_PICK && flags_nxt.mode != MODE_SET &&
        !flags_nxt.stable_level && flags_nxt.press_active &&
        CMP_W'(press_ticks_nxt) >= CMP_W'(cfg.hold_to_select)) begin
      flags_nxt.mode         = MODE_PICK;
      select_ticks_nxt       = '0;
      flags_nxt.press_active = 1'b0;
      press_ticks_nxt        = '0;
    end

    res.mode             = flags_nxt.mode;
    res.selection_is_set = pot_set;
  end
endmodule
`default_nettype wire

// ===== rtl/core/dbcs_core.sv =====
`default_nettype none
module dbcs_core #(
  parameter int COUNT_BITS = dbcs_pkg::COUNT_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire dbcs_pkg::cfg_t cfg,
  dbcs_in_if.sink            in_chan,
  dbcs_out_if.source         out_chan
);
  import dbcs_pkg::*;
  `include "assert_macros.svh"

  logic     in_valid_r;
  in_item_t in_item_r;
  logic     out_valid_r;
  res_t     res_r;
  logic     adv;
  logic     in_fire;

  flags_t                flags_r;
  flags_t                flags_nxt;
  logic [COUNT_BITS-1:0] stable_ticks_r, stable_ticks_nxt;
  logic [COUNT_BITS-1:0] press_ticks_r, press_ticks_nxt;
  logic [COUNT_BITS-1:0] select_ticks_r, select_ticks_nxt;
  res_t                  res_nxt;

  // word moves from the input register into the result register
  assign adv            = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !in_valid_r || adv;
  assign in_fire        = in_chan.valid && in_chan.ready;

  dbcs_step #(.COUNT_BITS(COUNT_BITS)) u_step (
    .cfg              (cfg),
    .item             (in_item_r),
    .flags            (flags_r),
    .stable_ticks     (stable_ticks_r),
    .press_ticks      (press_ticks_r),
    .select_ticks     (select_ticks_r),
    .flags_nxt        (flags_nxt),
    .stable_ticks_nxt (stable_ticks_nxt),
    .press_ticks_nxt  (press_ticks_nxt),
    .select_ticks_nxt (select_ticks_nxt),
    .res              (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r           <= 1'b0;
      out_valid_r          <= 1'b0;
      flags_r.last_raw     <= 1'b1;
      flags_r.stable_level <= 1'b1;
      flags_r.press_active <= 1'b0;
      flags_r.mode         <= MODE_CLOCK;
      stable_ticks_r       <= '0;
      press_ticks_r        <= '0;
      select_ticks_r       <= '0;
    end else begin
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (adv) begin
        out_valid_r    <= 1'b1;
        flags_r        <= flags_nxt;
        stable_ticks_r <= stable_ticks_nxt;
        press_ticks_r  <= press_ticks_nxt;
        select_ticks_r <= select_ticks_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.raw_button     <= in_chan.raw_button;
      in_item_r.pot_value      <= in_chan.pot_value;
      in_item_r.current_hour   <= in_chan.current_hour;
      in_item_r.current_minute <= in_chan.current_minute;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.mode             = res_r.mode;
  assign out_chan.set_valid        = res_r.set_valid;
  assign out_chan.set_hour         = res_r.set_hour;
  assign out_chan.set_minute       = res_r.set_minute;
  assign out_chan.selection_is_set = res_r.selection_is_set;

  `ASSERT_CLK(a_set_only_in_set_mode,
              (out_valid_r && res_r.set_valid) |-> (res_r.mode == MODE_SET),
              "time write outside set mode")
  `ASSERT_CLK(a_state_moves_on_adv,
              (!adv) |=> ($stable(flags_r) && $stable(press_ticks_r)),
              "button state changed without a word")
  `ASSERT_CLK(a_no_clock_to_set,
              (adv && flags_r.mode == MODE_CLOCK) |=> (flags_r.mode != MODE_SET),
              "clock mode jumped straight to set mode")
  `ASSERT_CLK(a_stall_holds_input,
              (!in_chan.ready) |-> (in_valid_r && out_valid_r),
              "input stalled with room downstream")
endmodule
`default_nettype wire

// ===== rtl/core/debounced_button_clock_setter.sv =====
// Pipeline: an accepted input word is held in the input register; its result is then
// written to the result register when that register is empty or being taken.
// Throughput: one word per cycle unless out_chan stalls; each word's compares and
// counter updates settle in one pass of the step logic between the two registers.
// Reset: synchronous active-low rst_n; restores config defaults, button released,
// counters cleared, clock mode, both pipeline registers empty.
`default_nettype none
module debounced_button_clock_setter #(
  parameter int COUNT_BITS = dbcs_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dbcs_in_if.sink                              in_chan,
  dbcs_out_if.source                           out_chan,
  input  wire logic                            cfg_we,
  input  wire logic [dbcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dbcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dbcs_pkg::*;

  cfg_t cfg;

  dbcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dbcs_core #(.COUNT_BITS(COUNT_BITS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );
endmodule
`default_nettype wire
